@@ src/s3c_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3c_pkg
// Shared widths, register indexes, reset values and control types of the
// separable 3x3 convolution block.
// ----------------------------------------------------------------------------
package s3c_pkg;

	// default sizes of the frame the line stores are built for
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// field widths
	localparam int PIX_W      = 16;
	localparam int COEF_W     = 8;
	localparam int HSUM_W     = 25;
	localparam int PROD_W     = 33;
	localparam int VSUM_W     = 34;
	localparam int OCOL_W     = 10;
	localparam int OROW_W     = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int IW_W       = 11;
	localparam int IH_W       = 13;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_H0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_H1      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_H2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_V0      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_V1      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_V2      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd7;

	// register reset values
	localparam logic signed [COEF_W-1:0] RST_COEF_H0 = -8'sd1;
	localparam logic signed [COEF_W-1:0] RST_COEF_H1 = 8'sd0;
	localparam logic signed [COEF_W-1:0] RST_COEF_H2 = 8'sd1;
	localparam logic signed [COEF_W-1:0] RST_COEF_V0 = 8'sd1;
	localparam logic signed [COEF_W-1:0] RST_COEF_V1 = 8'sd2;
	localparam logic signed [COEF_W-1:0] RST_COEF_V2 = 8'sd1;
	localparam int RST_IMAGE_WIDTH  = 1024;
	localparam int RST_IMAGE_HEIGHT = 4096;

	// smallest frame size in use
	localparam int MIN_SIZE = 3;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_FIN,
		ST_WB
	} ctrl_state_t;

	// multiply steps of the shared multiplier
	typedef enum logic [2:0] {
		STEP_H0,
		STEP_H1,
		STEP_H2,
		STEP_V0,
		STEP_V1,
		STEP_V2
	} mac_step_t;

	// commands from controller to datapath
	typedef struct packed {
		logic      load;
		logic      step_en;
		mac_step_t sel;
		logic      acc_clr;
		logic      acc_restart;
		logic      acc_add;
		logic      h_save;
		logic      store_wr;
		logic      out_load;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic has_h;
		logic has_out;
		logic out_busy;
	} dp_status_t;

endpackage

@@ src/s3c_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3c_ctrl
// Sequencer: takes an item and, from column 2 on, runs six multiply steps on
// the shared multiplier, writes the line stores and hands any result to the output.
// ----------------------------------------------------------------------------
module s3c_ctrl import s3c_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;
	mac_step_t   step_q, step_d;
	logic        accept;

	assign pix_stall = (state_q != ST_IDLE);
	assign accept    = pix_valid && !pix_stall;

	// state and step registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_H0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			ST_IDLE: begin
				step_d = STEP_H0;
				if (accept && status.has_h) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				case (step_q)
					STEP_H0: step_d = STEP_H1;
					STEP_H1: step_d = STEP_H2;
					STEP_H2: step_d = STEP_V0;
					STEP_V0: step_d = STEP_V1;
					STEP_V1: step_d = STEP_V2;
					default: step_d = STEP_H0;
				endcase
				if (step_q == STEP_V2) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				if (!status.has_out || !status.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd             = '0;
		cmd.sel         = step_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = accept;
			end
			ST_MAC: begin
				cmd.step_en     = 1'b1;
				cmd.acc_clr     = (step_q == STEP_H0);
				cmd.acc_restart = (step_q == STEP_V1);
				cmd.h_save      = (step_q == STEP_V1);
				cmd.acc_add     = (step_q != STEP_H0) && (step_q != STEP_V1);
			end
			ST_FIN: begin
				cmd.acc_add  = 1'b1;
				cmd.store_wr = 1'b1;
			end
			ST_WB: begin
				cmd.out_load = status.has_out && !status.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ src/s3c_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3c_datapath
// Config registers, raster counters, pixel history, two line stores, the
// shared multiply-accumulate unit and the output register.
// ----------------------------------------------------------------------------
module s3c_datapath import s3c_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [PIX_W-1:0]      pixel,
	input  dp_cmd_t                      cmd,
	output dp_status_t                   status,
	input  logic                         res_stall,
	output logic                         res_valid,
	output logic signed [VSUM_W-1:0]     filtered_value,
	output logic [OCOL_W-1:0]            out_column,
	output logic [OROW_W-1:0]            out_row,
	output logic                         frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int RST_W_USE = (RST_IMAGE_WIDTH  > MAX_WIDTH)  ? MAX_WIDTH  : RST_IMAGE_WIDTH;
	localparam int RST_H_USE = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;

	// config registers
	logic signed [COEF_W-1:0] coef_h0_q, coef_h1_q, coef_h2_q;
	logic signed [COEF_W-1:0] coef_v0_q, coef_v1_q, coef_v2_q;
	logic [CW-1:0]            w_last_q, w_last_d;
	logic [RW-1:0]            h_last_q, h_last_d;
	int                       w_val, h_val;

	// clamp the frame size on write, keep the last index
	always_comb begin
		w_val = int'(cfg_data[IW_W-1:0]);
		h_val = int'(cfg_data[IH_W-1:0]);
		if (w_val < MIN_SIZE) w_val = MIN_SIZE;
		if (w_val > MAX_WIDTH) w_val = MAX_WIDTH;
		if (h_val < MIN_SIZE) h_val = MIN_SIZE;
		if (h_val > MAX_HEIGHT) h_val = MAX_HEIGHT;
		w_last_d = CW'(w_val - 1);
		h_last_d = RW'(h_val - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_h0_q <= RST_COEF_H0;
			coef_h1_q <= RST_COEF_H1;
			coef_h2_q <= RST_COEF_H2;
			coef_v0_q <= RST_COEF_V0;
			coef_v1_q <= RST_COEF_V1;
			coef_v2_q <= RST_COEF_V2;
			w_last_q  <= CW'(RST_W_USE - 1);
			h_last_q  <= RW'(RST_H_USE - 1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_H0:      coef_h0_q <= cfg_data[COEF_W-1:0];
				REG_COEF_H1:      coef_h1_q <= cfg_data[COEF_W-1:0];
				REG_COEF_H2:      coef_h2_q <= cfg_data[COEF_W-1:0];
				REG_COEF_V0:      coef_v0_q <= cfg_data[COEF_W-1:0];
				REG_COEF_V1:      coef_v1_q <= cfg_data[COEF_W-1:0];
				REG_COEF_V2:      coef_v2_q <= cfg_data[COEF_W-1:0];
				REG_IMAGE_WIDTH:  w_last_q  <= w_last_d;
				REG_IMAGE_HEIGHT: h_last_q  <= h_last_d;
				default:          coef_h0_q <= coef_h0_q;
			endcase
		end
	end

	// raster counters and pixel history
	logic [CW-1:0]           col_q;
	logic [RW-1:0]           row_q;
	logic signed [PIX_W-1:0] prev1_q, prev2_q;
	logic [CW-1:0]           rd_addr;

	assign rd_addr = col_q - CW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			prev1_q <= '0;
			prev2_q <= '0;
		end else if (cmd.load) begin
			prev2_q <= prev1_q;
			prev1_q <= pixel;
			if (col_q >= w_last_q) begin
				col_q <= '0;
				if (row_q >= h_last_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// item snapshot taken at accept
	logic signed [PIX_W-1:0] op_p2_q, op_p1_q, op_px_q;
	logic [CW-1:0]           idx_q;
	logic [RW-1:0]           orow_q;
	logic                    last_q;
	logic                    has_out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_p2_q   <= prev2_q;
			op_p1_q   <= prev1_q;
			op_px_q   <= pixel;
			idx_q     <= rd_addr;
			orow_q    <= row_q - RW'(2);
			last_q    <= (row_q == h_last_q) && (col_q == w_last_q);
			has_out_q <= (row_q >= RW'(2));
		end
	end

	// line stores, registered read at accept, write once per item from column 2 on
	logic signed [HSUM_W-1:0] store_older [MAX_WIDTH];
	logic signed [HSUM_W-1:0] store_newer [MAX_WIDTH];
	logic signed [HSUM_W-1:0] older_rd_q, newer_rd_q;
	logic signed [HSUM_W-1:0] h_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			older_rd_q <= store_older[rd_addr];
			newer_rd_q <= store_newer[rd_addr];
		end
		if (cmd.store_wr) begin
			store_older[idx_q] <= newer_rd_q;
			store_newer[idx_q] <= h_q;
		end
	end

	// shared multiplier operand select
	logic signed [HSUM_W-1:0] mul_a;
	logic signed [COEF_W-1:0] mul_b;

	always_comb begin
		case (cmd.sel)
			STEP_H0: begin
				mul_a = {{(HSUM_W-PIX_W){op_p2_q[PIX_W-1]}}, op_p2_q};
				mul_b = coef_h0_q;
			end
			STEP_H1: begin
				mul_a = {{(HSUM_W-PIX_W){op_p1_q[PIX_W-1]}}, op_p1_q};
				mul_b = coef_h1_q;
			end
			STEP_H2: begin
				mul_a = {{(HSUM_W-PIX_W){op_px_q[PIX_W-1]}}, op_px_q};
				mul_b = coef_h2_q;
			end
			STEP_V0: begin
				mul_a = older_rd_q;
				mul_b = coef_v0_q;
			end
			STEP_V1: begin
				mul_a = newer_rd_q;
				mul_b = coef_v1_q;
			end
			STEP_V2: begin
				mul_a = h_q;
				mul_b = coef_v2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product register, then accumulate
	logic signed [PROD_W-1:0] prod_q;
	logic signed [VSUM_W-1:0] acc_q;
	logic signed [VSUM_W-1:0] prod_ext;
	logic signed [PROD_W-1:0] prod_d;

	assign prod_d   = mul_a * mul_b;
	assign prod_ext = {prod_q[PROD_W-1], prod_q};

	always_ff @(posedge clk) begin
		if (cmd.step_en) begin
			prod_q <= prod_d;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_restart) begin
			acc_q <= prod_ext;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_ext;
		end
		// horizontal sum is complete in the accumulator at this step
		if (cmd.h_save) begin
			h_q <= acc_q[HSUM_W-1:0];
		end
	end

	// output register
	logic res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			filtered_value <= acc_q;
			out_column     <= OCOL_W'(idx_q);
			out_row        <= OROW_W'(orow_q);
			frame_end      <= last_q;
		end
	end

	assign res_valid = res_valid_q;

	// status to controller
	assign status.has_h    = (col_q >= CW'(2));
	assign status.has_out  = has_out_q;
	assign status.out_busy = res_valid_q && res_stall;

endmodule

@@ src/separable_3x3_convolution_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_3x3_convolution_top
// Separable 3x3 filter over a raster pixel stream, valid region only.
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel (pix_valid / pix_stall): one signed 16-bit pixel per item,
//   in raster order. The frame counters wrap, so frames follow back to back.
//   result channel (res_valid / res_stall): one item per input pixel whose
//   row and column are both at least 2, carrying the exact 34-bit sum, its
//   output column and row, and frame_end on the last result of the frame.
//   config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//   the taps and the frame size only while the block is idle.
// Sequence:
//   pixels in columns 0 and 1 only enter the pixel history. Every other
//   pixel is taken with a read of the line stores, then runs the multiply
//   steps on the one shared 25x8 multiplier, writes the line stores and,
//   for a result, loads the output register; res_valid rises the cycle after.
//   While the receiver stalls, the output register holds and the next pixel
//   is still taken and worked on; it waits at the output load only.
// Reset: taps and frame size go to their defaults, counters and pixel
//   history clear; the line stores are not cleared.
// ----------------------------------------------------------------------------
module separable_3x3_convolution_top import s3c_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     pix_valid,
	output logic                     pix_stall,
	input  logic signed [PIX_W-1:0]  pixel,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic signed [VSUM_W-1:0] filtered_value,
	output logic [OCOL_W-1:0]        out_column,
	output logic [OROW_W-1:0]        out_row,
	output logic                     frame_end
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       cfg_we;

	// config writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencer
	s3c_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	s3c_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixel          (pixel),
		.cmd            (cmd),
		.status         (status),
		.res_stall      (res_stall),
		.res_valid      (res_valid),
		.filtered_value (filtered_value),
		.out_column     (out_column),
		.out_row        (out_row),
		.frame_end      (frame_end)
	);

endmodule

@@ sim/separable_3x3_convolution_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_3x3_convolution_checker
// Watches the config, pixel and result channels of the separable 3x3
// convolution. Keeps its own copy of the taps, the frame size, the pixel
// history, the frame position and both line stores, predicts each result
// that an accepted pixel causes and compares each accepted result item, in
// order, field by field.
// ----------------------------------------------------------------------------
module separable_3x3_convolution_checker import s3c_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     pix_valid,
	input  logic                     pix_stall,
	input  logic signed [PIX_W-1:0]  pixel,
	input  logic                     res_valid,
	input  logic                     res_stall,
	input  logic signed [VSUM_W-1:0] filtered_value,
	input  logic [OCOL_W-1:0]        out_column,
	input  logic [OROW_W-1:0]        out_row,
	input  logic                     frame_end,
	output int                       error_count,
	output int                       open_results,
	output int                       pixels_taken,
	output int                       results_checked,
	output int                       frames_closed
);

	typedef struct {
		logic signed [VSUM_W-1:0] sum;
		logic [OCOL_W-1:0]        column;
		logic [OROW_W-1:0]        row;
		logic                     last;
	} filter_result_t;

	// taps and frame size as written
	logic signed [COEF_W-1:0] tap_h [3];
	logic signed [COEF_W-1:0] tap_v [3];
	logic [IW_W-1:0]          width_reg;
	logic [IH_W-1:0]          height_reg;

	// pixel history, frame position and line stores
	logic signed [PIX_W-1:0]  px_d1;
	logic signed [PIX_W-1:0]  px_d2;
	logic [OCOL_W-1:0]        col_pos;
	logic [OROW_W-1:0]        row_pos;
	logic signed [HSUM_W-1:0] store_older [DEF_MAX_WIDTH];
	logic signed [HSUM_W-1:0] store_newer [DEF_MAX_WIDTH];

	filter_result_t expected_results [$];
	filter_result_t oldest;
	int errors = 0;
	int taken = 0;
	int checked = 0;
	int closed = 0;

	// frame size in use, clamped to the supported range
	function automatic int size_in_use(int v, int hi);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// only the first ten failures are printed
	function automatic void log_failure(string msg);
		errors++;
		if (errors <= 10)
			$display("checker: %s", msg);
	endfunction

	// one pixel through the filter, queueing the result it causes
	task automatic filter_pixel(input logic signed [PIX_W-1:0] px);
		int w_use;
		int h_use;
		logic [OCOL_W-1:0] idx;
		logic signed [HSUM_W-1:0] hsum;
		filter_result_t res;
		w_use = size_in_use(int'(width_reg), DEF_MAX_WIDTH);
		h_use = size_in_use(int'(height_reg), DEF_MAX_HEIGHT);
		// horizontal sum from column 2 on, vertical sum from row 2 on
		if (col_pos >= 2) begin
			idx = col_pos - 2'd2;
			hsum = tap_h[0] * px_d2 + tap_h[1] * px_d1 + tap_h[2] * px;
			if (row_pos >= 2) begin
				res.sum = tap_v[0] * store_older[idx] + tap_v[1] * store_newer[idx]
					+ tap_v[2] * hsum;
				res.column = idx;
				res.row = row_pos - 2'd2;
				res.last = (int'(row_pos) == h_use - 1) && (int'(col_pos) == w_use - 1);
				expected_results.push_back(res);
			end
			store_older[idx] = store_newer[idx];
			store_newer[idx] = hsum;
		end
		px_d2 = px_d1;
		px_d1 = px;
		// counters compare with >=, so a shrunk size wraps at the next step
		if (int'(col_pos) + 1 >= w_use) begin
			col_pos = '0;
			if (int'(row_pos) + 1 >= h_use)
				row_pos = '0;
			else
				row_pos = row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_h[0] = RST_COEF_H0;
			tap_h[1] = RST_COEF_H1;
			tap_h[2] = RST_COEF_H2;
			tap_v[0] = RST_COEF_V0;
			tap_v[1] = RST_COEF_V1;
			tap_v[2] = RST_COEF_V2;
			width_reg = IW_W'(RST_IMAGE_WIDTH);
			height_reg = IH_W'(RST_IMAGE_HEIGHT);
			px_d1 = '0;
			px_d2 = '0;
			col_pos = '0;
			row_pos = '0;
			expected_results.delete();
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COEF_H0:      tap_h[0] = cfg_data[COEF_W-1:0];
					REG_COEF_H1:      tap_h[1] = cfg_data[COEF_W-1:0];
					REG_COEF_H2:      tap_h[2] = cfg_data[COEF_W-1:0];
					REG_COEF_V0:      tap_v[0] = cfg_data[COEF_W-1:0];
					REG_COEF_V1:      tap_v[1] = cfg_data[COEF_W-1:0];
					REG_COEF_V2:      tap_v[2] = cfg_data[COEF_W-1:0];
					REG_IMAGE_WIDTH:  width_reg = cfg_data[IW_W-1:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_data[IH_W-1:0];
					default: ;
				endcase
			end
			// result items against the oldest prediction
			if (res_valid && !res_stall) begin
				checked++;
				if (frame_end)
					closed++;
				if (expected_results.size() == 0) begin
					log_failure($sformatf("unexpected result: sum %0d col %0d row %0d end %0b",
						filtered_value, out_column, out_row, frame_end));
				end else begin
					oldest = expected_results.pop_front();
					if (filtered_value !== oldest.sum || out_column !== oldest.column
						|| out_row !== oldest.row || frame_end !== oldest.last) begin
						log_failure($sformatf({"mismatch: expected sum %0d col %0d row %0d ",
							"end %0b, got sum %0d col %0d row %0d end %0b"},
							oldest.sum, oldest.column, oldest.row, oldest.last,
							filtered_value, out_column, out_row, frame_end));
					end
				end
			end
			// pixel items
			if (pix_valid && !pix_stall) begin
				taken++;
				filter_pixel(pixel);
			end
		end
		error_count <= errors;
		open_results <= expected_results.size();
		pixels_taken <= taken;
		results_checked <= checked;
		frames_closed <= closed;
	end

endmodule

@@ sim/separable_3x3_convolution_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_3x3_convolution_top_tb
// Drives pixels and tap / frame size settings into the separable 3x3
// convolution with random gaps and random result back-pressure: a short
// directed run with extreme taps and pixels, one full-width pass, a
// mid-frame size change, then random settings and pixels. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module separable_3x3_convolution_top_tb;
	import s3c_pkg::*;

	localparam int CLOCK_HALF    = 2;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_PIXELS = 600;
	localparam int IDLE_PERCENT  = 34;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_COEF_H0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     pix_valid = 1'b0;
	logic                     pix_stall;
	logic signed [PIX_W-1:0]  pixel = '0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	logic signed [VSUM_W-1:0] filtered_value;
	logic [OCOL_W-1:0]        out_column;
	logic [OROW_W-1:0]        out_row;
	logic                     frame_end;

	int error_count;
	int open_results;
	int pixels_taken;
	int results_checked;
	int frames_closed;
	int cycle_count = 0;
	int setting_count = 0;
	logic steady = 1'b0;
	reg_write_t setting_writes [$];

	always begin
		#CLOCK_HALF clk = 1'b1;
		#CLOCK_HALF clk = 1'b0;
	end

	separable_3x3_convolution_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pix_valid      (pix_valid),
		.pix_stall      (pix_stall),
		.pixel          (pixel),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.filtered_value (filtered_value),
		.out_column     (out_column),
		.out_row        (out_row),
		.frame_end      (frame_end)
	);

	separable_3x3_convolution_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pix_valid       (pix_valid),
		.pix_stall       (pix_stall),
		.pixel           (pixel),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.filtered_value  (filtered_value),
		.out_column      (out_column),
		.out_row         (out_row),
		.frame_end       (frame_end),
		.error_count     (error_count),
		.open_results    (open_results),
		.pixels_taken    (pixels_taken),
		.results_checked (results_checked),
		.frames_closed   (frames_closed)
	);

	// random back-pressure on results
	always @(posedge clk) begin
		res_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("separable_3x3_convolution_top_tb: done, errors");
			$finish;
		end
	end

	// tap word with random unused upper bits
	function automatic logic [CFG_DATA_W-1:0] tap_word(logic signed [COEF_W-1:0] t);
		return {(CFG_DATA_W-COEF_W)'($urandom), t};
	endfunction

	// width word with random unused upper bits
	function automatic logic [CFG_DATA_W-1:0] width_word(int w);
		return {(CFG_DATA_W-IW_W)'($urandom), IW_W'(w)};
	endfunction

	function automatic logic signed [COEF_W-1:0] pick_tap();
		case ($urandom_range(0, 7))
			0:       return -8'sd128;
			1:       return 8'sd127;
			2:       return 8'sd0;
			3:       return -8'sd1;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0:       return -16'sd32768;
			1:       return 16'sd32767;
			2:       return 16'sd0;
			3:       return -16'sd1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// mostly small widths, sometimes clamped or wide ones
	function automatic int pick_width();
		case ($urandom_range(0, 19))
			0:       return $urandom_range(0, 2);
			1:       return DEF_MAX_WIDTH;
			2:       return 2047;
			3:       return $urandom_range(DEF_MAX_WIDTH + 1, 2047);
			4:       return $urandom_range(11, DEF_MAX_WIDTH - 1);
			default: return $urandom_range(MIN_SIZE, 10);
		endcase
	endfunction

	function automatic int pick_height();
		case ($urandom_range(0, 19))
			0:       return $urandom_range(0, 2);
			1:       return DEF_MAX_HEIGHT;
			2:       return 8191;
			3:       return $urandom_range(DEF_MAX_HEIGHT + 1, 8191);
			4:       return $urandom_range(9, DEF_MAX_HEIGHT - 1);
			default: return $urandom_range(MIN_SIZE, 6);
		endcase
	endfunction

	function automatic void queue_write(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] data);
		setting_writes.push_back({idx, data});
	endfunction

	// send the queued register writes back to back
	task automatic write_settings();
		reg_write_t w;
		setting_count++;
		while (setting_writes.size() != 0) begin
			w = setting_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data <= w.data;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// one pixel item, with a random gap in front unless steady
	task automatic send_pixel(input logic signed [PIX_W-1:0] v);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				pix_valid <= 1'b0;
				@(posedge clk);
			end
		end
		pix_valid <= 1'b1;
		pixel <= v;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
	endtask

	task automatic send_random_pixels(input int n);
		repeat (n)
			send_pixel(pick_pixel());
	endtask

	// stop sending, wait for every predicted result, then let the block settle
	task automatic drain_and_settle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		int random_sent;
		int burst;
		logic all_regs;
		random_sent = 0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default taps on the smallest frame, extreme pixels
		queue_write(REG_IMAGE_WIDTH, width_word(MIN_SIZE));
		queue_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(MIN_SIZE));
		write_settings();
		send_pixel(-16'sd32768);
		send_pixel(16'sd32767);
		send_pixel(16'sd0);
		send_pixel(-16'sd1);
		send_pixel(16'sd1);
		send_pixel(16'sd32767);
		send_pixel(16'sd32767);
		send_pixel(-16'sd32768);
		send_pixel(-16'sd32768);
		drain_and_settle();

		// all taps at the negative extreme: most negative sum
		queue_write(REG_COEF_H0, tap_word(-8'sd128));
		queue_write(REG_COEF_H1, tap_word(-8'sd128));
		queue_write(REG_COEF_H2, tap_word(-8'sd128));
		queue_write(REG_COEF_V0, tap_word(-8'sd128));
		queue_write(REG_COEF_V1, tap_word(-8'sd128));
		queue_write(REG_COEF_V2, tap_word(-8'sd128));
		write_settings();
		repeat (9)
			send_pixel(-16'sd32768);
		drain_and_settle();

		// vertical taps at the positive extreme: large positive sum
		queue_write(REG_COEF_V0, tap_word(8'sd127));
		queue_write(REG_COEF_V1, tap_word(8'sd127));
		queue_write(REG_COEF_V2, tap_word(8'sd127));
		write_settings();
		repeat (9)
			send_pixel(-16'sd32768);
		drain_and_settle();

		// full width (clamped from the top code), fills the line stores for every output column,
		// stops in the middle of the last row
		queue_write(REG_IMAGE_WIDTH, width_word(2047));
		queue_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(4));
		queue_write(REG_COEF_H0, tap_word(pick_tap()));
		queue_write(REG_COEF_H1, tap_word(pick_tap()));
		queue_write(REG_COEF_H2, tap_word(pick_tap()));
		write_settings();
		steady <= 1'b1;
		send_random_pixels(3 * DEF_MAX_WIDTH + 600);
		drain_and_settle();
		steady <= 1'b0;

		// width shrunk below the current column mid-frame
		queue_write(REG_IMAGE_WIDTH, width_word(4));
		write_settings();
		send_random_pixels(30);
		random_sent = 30;

		// random settings, random pixels, random stop points
		while (random_sent < RANDOM_PIXELS) begin
			drain_and_settle();
			all_regs = ($urandom_range(0, 3) == 0);
			if (all_regs || $urandom_range(0, 1))
				queue_write(REG_COEF_H0, tap_word(pick_tap()));
			if (all_regs || $urandom_range(0, 1))
				queue_write(REG_COEF_H1, tap_word(pick_tap()));
			if (all_regs || $urandom_range(0, 1))
				queue_write(REG_COEF_H2, tap_word(pick_tap()));
			if (all_regs || $urandom_range(0, 1))
				queue_write(REG_COEF_V0, tap_word(pick_tap()));
			if (all_regs || $urandom_range(0, 1))
				queue_write(REG_COEF_V1, tap_word(pick_tap()));
			if (all_regs || $urandom_range(0, 1))
				queue_write(REG_COEF_V2, tap_word(pick_tap()));
			if (all_regs || $urandom_range(0, 1))
				queue_write(REG_IMAGE_WIDTH, width_word(pick_width()));
			if (all_regs || $urandom_range(0, 1))
				queue_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(pick_height()));
			write_settings();
			steady <= ($urandom_range(0, 4) == 0);
			burst = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(20, 120);
			send_random_pixels(burst);
			random_sent += burst;
		end
		drain_and_settle();

		$display("run covered %0d pixels over %0d register settings, extreme taps and pixels,",
			pixels_taken, setting_count);
		$display("clamped and mid-frame sizes; %0d results compared, %0d closing a frame",
			results_checked, frames_closed);
		if (error_count == 0) begin
			$display("separable_3x3_convolution_top_tb: done, clean");
		end else begin
			$display("separable_3x3_convolution_top_tb: done, errors");
		end
		$finish;
	end

endmodule
